### sv/stl_pkg.sv
// stl_pkg: types, constants and per-byte scan function of the source text lexer.
// Used by source_text_lexer and its checker; no dependencies.
package stl_pkg;

  localparam int OFF_BITS   = 24;
  localparam int DEPTH_BITS = 16;
  localparam int KW_MAX_LEN = 7;
  localparam int LINE_BITS  = 20;
  localparam int COL_BITS   = 16;
  localparam int NUM_KW     = 13;

  localparam logic [OFF_BITS-1:0]   OFF_MAX   = {OFF_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]  LINE_SAT  = {LINE_BITS{1'b1}};
  localparam logic [COL_BITS-1:0]   COL_SAT   = {COL_BITS{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_CHARLIT, M_DOT, M_SLASH, M_CR,
    M_LCOMMENT, M_BCOMMENT, M_BC_SLASH, M_BC_STAR
  } mode_t;

  typedef enum logic [3:0] {
    K_CHAR, K_SLASH, K_DOT, K_BREAK, K_EOF, K_KEYWORD, K_IDENT, K_NUMBER,
    K_STRING, K_CHARLIT
  } kind_t;

  typedef struct packed {
    mode_t                        mode;
    logic [KW_MAX_LEN-1:0][7:0]   wbuf;
    logic [3:0]                   wlen;
    logic [DEPTH_BITS-1:0]        depth;
    logic [LINE_BITS-1:0]         line;
    logic [OFF_BITS-1:0]          lbeg;
    logic [OFF_BITS-1:0]          tbeg;
    logic [LINE_BITS-1:0]         tline;
    logic [COL_BITS-1:0]          tcol;
  } st_t;

  localparam st_t ST_RST = '{mode: M_IDLE, wbuf: '0, wlen: '0, depth: '0,
                             line: LINE_BITS'(1), lbeg: '0, tbeg: '0,
                             tline: LINE_BITS'(1), tcol: '0};

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            value;
    logic [OFF_BITS-1:0]   start;
    logic [OFF_BITS-1:0]   stop;
    logic [LINE_BITS-1:0]  line;
    logic [COL_BITS-1:0]   col;
    logic                  last;
  } tok_t;

  typedef struct packed {
    st_t                 s;
    logic                again;
    logic                emit;
    kind_t               kind;
    logic [7:0]          value;
    logic [OFF_BITS-1:0] stop;
  } hres_t;

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [55:0] kw_text(logic [3:0] k);
    logic [55:0] t;
    unique case (k)
      4'd0:    t = 56'("struct");
      4'd1:    t = 56'("type");
      4'd2:    t = 56'("if");
      4'd3:    t = 56'("else");
      4'd4:    t = 56'("defer");
      4'd5:    t = 56'("func");
      4'd6:    t = 56'("uninit");
      4'd7:    t = 56'("return");
      4'd8:    t = 56'("nullptr");
      4'd9:    t = 56'("null");
      4'd10:   t = 56'("i32");
      4'd11:   t = 56'("f32");
      4'd12:   t = 56'("bool");
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(logic [3:0] k);
    logic [3:0] l;
    unique case (k)
      4'd0, 4'd6, 4'd7:          l = 4'd6;
      4'd1, 4'd3, 4'd5, 4'd9,
      4'd12:                     l = 4'd4;
      4'd2:                      l = 4'd2;
      4'd4:                      l = 4'd5;
      4'd8:                      l = 4'd7;
      4'd10, 4'd11:              l = 4'd3;
      default:                   l = 4'd0;
    endcase
    return l;
  endfunction

  // {hit, index}; first listed keyword wins
  function automatic logic [4:0] kw_lookup(logic [KW_MAX_LEN-1:0][7:0] wbuf,
                                           logic [3:0] wlen);
    logic [4:0]  r;
    logic        same;
    logic [55:0] t;
    logic [3:0]  l;
    r = '0;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      t    = kw_text(4'(k));
      l    = kw_len(4'(k));
      same = (wlen == l);
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (4'(i) < l && wbuf[i] != t[8*(int'(l) - 1 - i) +: 8]) same = 1'b0;
      end
      if (same) r = {1'b1, 4'(k)};
    end
    return r;
  endfunction

  function automatic st_t begin_tok(st_t s, logic [OFF_BITS-1:0] pos);
    st_t                 o;
    logic [OFF_BITS-1:0] d;
    o       = s;
    o.tbeg  = pos;
    o.tline = s.line;
    d       = (pos >= s.lbeg) ? pos - s.lbeg : '0;
    o.tcol  = (d > OFF_BITS'(COL_SAT)) ? COL_SAT : d[COL_BITS-1:0];
    return o;
  endfunction

  function automatic st_t new_line(st_t s, logic [OFF_BITS-1:0] nxt);
    st_t o;
    o = s;
    if (s.line != LINE_SAT) o.line = s.line + 1'b1;
    o.lbeg = nxt;
    return o;
  endfunction

  // One scan pass over byte b in the current mode.
  function automatic hres_t lex_handle(st_t s, logic [7:0] b, logic [OFF_BITS-1:0] pos);
    hres_t               r;
    logic [OFF_BITS-1:0] past;
    logic [4:0]          kw;
    past    = (pos == OFF_MAX) ? pos : pos + 1'b1;
    r.s     = s;
    r.again = 1'b0;
    r.emit  = 1'b0;
    r.kind  = K_CHAR;
    r.value = '0;
    r.stop  = past;
    kw      = kw_lookup(s.wbuf, s.wlen);
    unique case (s.mode)
      M_IDLE: begin
        if (b != CH_SPACE && b != CH_TAB) begin
          r.s = begin_tok(s, pos);
          priority if (b == CH_NUL) begin
            r.emit = 1'b1;
            r.kind = K_EOF;
          end else if (is_alpha(b)) begin
            r.s.mode    = M_IDENT;
            r.s.wbuf[0] = b;
            r.s.wlen    = 4'd1;
          end else if (b == CH_DOT) begin
            r.s.mode = M_DOT;
          end else if (is_digit(b)) begin
            r.s.mode = M_NUMBER;
          end else if (b == CH_DQ) begin
            r.s.mode = M_STRING;
          end else if (b == CH_SQ) begin
            r.s.mode = M_CHARLIT;
          end else if (b == CH_SLASH) begin
            r.s.mode = M_SLASH;
          end else if (b == CH_CR) begin
            r.s.mode = M_CR;
          end else if (b == CH_LF) begin
            r.s    = new_line(r.s, past);
            r.emit = 1'b1;
            r.kind = K_BREAK;
          end else begin
            r.emit  = 1'b1;
            r.kind  = K_CHAR;
            r.value = b;
          end
        end
      end
      M_IDENT: begin
        if (is_alpha(b) || is_digit(b)) begin
          if (s.wlen < 4'(KW_MAX_LEN)) r.s.wbuf[s.wlen[2:0]] = b;
          if (s.wlen <= 4'(KW_MAX_LEN)) r.s.wlen = s.wlen + 1'b1;
        end else begin
          r.emit   = 1'b1;
          r.stop   = pos;
          r.kind   = kw[4] ? K_KEYWORD : K_IDENT;
          r.value  = kw[4] ? {4'd0, kw[3:0]} : 8'd0;
          r.s.mode = M_IDLE;
          r.again  = 1'b1;
        end
      end
      M_NUMBER: begin
        if (!(is_digit(b) || b == CH_DOT || b == "x" || b == "b")) begin
          r.emit   = 1'b1;
          r.kind   = K_NUMBER;
          r.stop   = pos;
          r.s.mode = M_IDLE;
          r.again  = 1'b1;
        end
      end
      M_STRING, M_CHARLIT: begin
        r.kind = (s.mode == M_STRING) ? K_STRING : K_CHARLIT;
        if (b == ((s.mode == M_STRING) ? CH_DQ : CH_SQ)) begin
          r.emit   = 1'b1;
          r.s.mode = M_IDLE;
        end else if (b == CH_NUL || b == CH_LF || b == CH_CR) begin
          r.emit   = 1'b1;
          r.stop   = pos;
          r.s.mode = M_IDLE;
          r.again  = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit(b)) begin
          r.s.mode = M_NUMBER;
        end else begin
          r.emit   = 1'b1;
          r.kind   = K_DOT;
          r.stop   = pos;
          r.s.mode = M_IDLE;
          r.again  = 1'b1;
        end
      end
      M_SLASH: begin
        priority if (b == CH_STAR) begin
          r.s.mode  = M_BCOMMENT;
          r.s.depth = DEPTH_BITS'(1);
        end else if (b == CH_SLASH) begin
          r.s.mode = M_LCOMMENT;
        end else begin
          r.emit   = 1'b1;
          r.kind   = K_SLASH;
          r.stop   = pos;
          r.s.mode = M_IDLE;
          r.again  = 1'b1;
        end
      end
      M_CR: begin
        r.emit   = 1'b1;
        r.kind   = K_BREAK;
        r.s.mode = M_IDLE;
        if (b == CH_LF) begin
          r.s = new_line(r.s, past);
        end else begin
          r.s     = new_line(r.s, pos);
          r.stop  = pos;
          r.again = 1'b1;
        end
      end
      M_LCOMMENT: begin
        if (b == CH_LF || b == CH_CR || b == CH_NUL) begin
          r.emit   = 1'b1;
          r.kind   = K_BREAK;
          r.stop   = pos;
          r.s.mode = M_IDLE;
          r.again  = 1'b1;
        end
      end
      M_BC_SLASH: begin
        r.s.mode = M_BCOMMENT;
        if (b == CH_STAR) begin
          if (s.depth != DEPTH_MAX) r.s.depth = s.depth + 1'b1;
        end else begin
          r.again = 1'b1;
        end
      end
      M_BC_STAR: begin
        r.s.mode = M_BCOMMENT;
        if (b == CH_SLASH) begin
          if (s.depth != '0) r.s.depth = s.depth - 1'b1;
          if (s.depth <= DEPTH_BITS'(1)) r.s.mode = M_IDLE;
        end else begin
          r.again = 1'b1;
        end
      end
      M_BCOMMENT: begin
        priority if (b == CH_NUL) begin
          r.s.depth = '0;
          r.s.mode  = M_IDLE;
          r.again   = 1'b1;
        end else if (b == CH_LF) begin
          r.s = new_line(s, past);
        end else if (b == CH_SLASH) begin
          r.s.mode = M_BC_SLASH;
        end else if (b == CH_STAR) begin
          r.s.mode = M_BC_STAR;
        end else begin
          r.s.mode = M_BCOMMENT;
        end
      end
      default: begin
        r.s.mode = M_IDLE;
        r.again  = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

### sv/source_text_lexer.sv
// source_text_lexer: scans one source byte per word and queues up to two tokens per byte.
// A token is registered into the token queue when the byte that closes it is accepted.
// Takes one byte per cycle while in_stall is low; a byte may close two tokens, and the
// 4-entry token queue raises in_stall while it holds > 2.
// Synchronous active-low reset returns scanner to idle, line 1, offset 0.
// Depends on stl_pkg.
module source_text_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [7:0]  out_tok_value,
  output logic [23:0] out_start_offset,
  output logic [23:0] out_end_offset,
  output logic [19:0] out_line_num,
  output logic [15:0] out_column_number,
  output logic        out_last_of_run
);

  stl_pkg::st_t                    st_r, st_nxt;
  logic [stl_pkg::OFF_BITS-1:0]    pos_r;
  stl_pkg::hres_t                  h;
  stl_pkg::tok_t                   t0, t1, tk;
  logic [1:0]                      n;
  logic                            go;
  stl_pkg::tok_t                   q_r [4];
  logic [1:0]                      wp_r, rp_r;
  logic [2:0]                      cnt_r;
  logic                            acc, pop;

  assign acc = in_valid && !in_stall;
  assign pop = out_valid && !out_stall;
  assign in_stall  = cnt_r > 3'd2;
  assign out_valid = cnt_r != 3'd0;

  always_comb begin
    st_nxt = st_r;
    go     = 1'b1;
    n      = 2'd0;
    t0     = '0;
    t1     = '0;
    tk     = '0;
    h      = '0;
    for (int p = 0; p < 3; p++) begin
      if (go) begin
        h        = stl_pkg::lex_handle(st_nxt, in_byte, pos_r);
        st_nxt   = h.s;
        tk.kind  = h.kind;
        tk.value = h.value;
        tk.start = h.s.tbeg;
        tk.stop  = h.stop;
        tk.line  = h.s.tline;
        tk.col   = h.s.tcol;
        tk.last  = 1'b0;
        if (h.emit) begin
          if (n == 2'd0) t0 = tk;
          else t1 = tk;
          n = n + 1'b1;
        end
        go = h.again;
      end
    end
    if (n == 2'd1) t0.last = 1'b1;
    t1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= stl_pkg::ST_RST;
      pos_r      <= '0;
      wp_r       <= '0;
      rp_r       <= '0;
      cnt_r      <= '0;
    end else begin
      if (acc) begin
        st_r  <= st_nxt;
        pos_r <= (pos_r == stl_pkg::OFF_MAX) ? pos_r : pos_r + 1'b1;
        wp_r  <= wp_r + n;
      end
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (acc ? {1'b0, n} : 3'd0) - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (acc && n != 2'd0) q_r[wp_r] <= t0;
    if (acc && n == 2'd2) q_r[wp_r + 2'd1] <= t1;
  end

  assign out_token_kind    = q_r[rp_r].kind;
  assign out_tok_value     = q_r[rp_r].value;
  assign out_start_offset  = q_r[rp_r].start;
  assign out_end_offset    = q_r[rp_r].stop;
  assign out_line_num      = q_r[rp_r].line;
  assign out_column_number = q_r[rp_r].col;
  assign out_last_of_run   = q_r[rp_r].last;

endmodule

### sv/stl_checker.sv
// stl_checker: port-level assertions for source_text_lexer, bound to the top.
// Depends on stl_pkg for token kind codes.
module stl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_token_kind,
  input logic [7:0]  out_tok_value,
  input logic [23:0] out_start_offset,
  input logic [23:0] out_end_offset,
  input logic [19:0] out_line_num
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_end_offset))
    else $error("stalled word changed");

  a_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_num != 20'd0)
    else $error("line number zero");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_end_offset >= out_start_offset)
    else $error("token ends before start");

  a_kw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == 4'(stl_pkg::K_KEYWORD) |-> out_tok_value < 8'd13)
    else $error("bad keyword index");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("not empty after reset");

endmodule

bind source_text_lexer stl_checker u_stl_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_token_kind(out_token_kind),
  .out_tok_value(out_tok_value), .out_start_offset(out_start_offset),
  .out_end_offset(out_end_offset), .out_line_num(out_line_num)
);
